@@ hdl/assert_macros.svh @@
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define SST_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("sst assertion failed");

// Next-cycle implication, off during reset.
`define SST_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sst assertion failed");

`endif

@@ hdl/sst_pkg.sv @@
// Types and constants of the sparse slot table.
package sst_pkg;

  localparam int IDX_W   = 12;
  localparam int CNT_W   = 13;
  localparam int DATA_W  = 32;
  localparam int FUNC_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_PUT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FIND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAIT,
    ST_HOLD
  } state_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic             active;
    logic             found;
    logic [IDX_W-1:0] idx;
  } tok_t;

  typedef struct packed {
    logic wr;
    logic clr;
  } cell_ctl_t;

  typedef struct packed {
    logic             placed;
    logic [CNT_W-1:0] run_placed;
    logic             found;
    logic [IDX_W-1:0] match_index;
    logic [CNT_W-1:0] valid_count;
    logic             status;
  } res_t;

endpackage

@@ hdl/sst_in_if.sv @@
// Input item channel of the sparse slot table.
interface sst_in_if;
  logic                        valid;
  logic                        ready;
  logic [sst_pkg::FUNC_W-1:0]  func;
  logic [sst_pkg::IDX_W-1:0]   slot_index;
  logic [sst_pkg::DATA_W-1:0]  data_value;
  logic                        run_last;

  modport source (output valid, func, slot_index, data_value, run_last, input ready);
  modport sink   (input valid, func, slot_index, data_value, run_last, output ready);
endinterface

@@ hdl/sst_out_if.sv @@
// Result item channel of the sparse slot table.
interface sst_out_if;
  logic                       valid;
  logic                       ready;
  logic                       placed;
  logic [sst_pkg::CNT_W-1:0]  run_placed;
  logic                       found;
  logic [sst_pkg::IDX_W-1:0]  match_index;
  logic [sst_pkg::CNT_W-1:0]  valid_count;
  logic                       status;

  modport source (output valid, placed, run_placed, found, match_index, valid_count,
                  status, input ready);
  modport sink   (input valid, placed, run_placed, found, match_index, valid_count,
                  status, output ready);
endinterface

@@ hdl/sst_cell.sv @@
// One slot cell: value, valid bit and one stage of the search token chain.
module sst_cell #(
  parameter int VALUE_WIDTH = 32,
  parameter int CELL_INDEX  = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sst_pkg::cell_ctl_t     ctl,
  input  logic [VALUE_WIDTH-1:0] wr_value,
  input  logic [VALUE_WIDTH-1:0] key,
  input  sst_pkg::tok_t          tok_i,
  output sst_pkg::tok_t          tok_o,
  output logic                   valid_o
);

  logic [VALUE_WIDTH-1:0] value_r;
  logic                   valid_r;
  logic                   tok_active_r;
  logic                   tok_found_r;
  logic [sst_pkg::IDX_W-1:0] tok_idx_r;
  logic                   hit;

  assign hit = tok_i.active && valid_r && (value_r == key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      tok_active_r <= 1'b0;
    end else begin
      tok_active_r <= tok_i.active;
      if (ctl.wr) begin
        valid_r <= 1'b1;
      end else if (ctl.clr) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      value_r <= wr_value;
    end
    tok_found_r <= tok_i.found || hit;
    tok_idx_r   <= tok_i.found ? tok_i.idx : sst_pkg::IDX_W'(CELL_INDEX);
  end

  assign tok_o   = '{active: tok_active_r, found: tok_found_r, idx: tok_idx_r};
  assign valid_o = valid_r;

endmodule

@@ hdl/sparse_slot_table.sv @@
// Top level of the sparse slot table: control, counters and the row of slot cells.
//
// Usage: items enter on in_if (valid/ready), one result item per input item leaves on
// out_if (valid/ready), in order. func selects put, find or delete.
// Put and delete (and the unused code) are decided in the cycle after acceptance; the
// result is registered in res_r and then moved into the output register.
// A find injects a search token at cell 0; the token moves one cell per clock through
// the chain of DEPTH cells, keeping the lowest match, and the result is taken when the
// token leaves the last cell.
// One item is in work at a time; in_if.ready rises again when the result is moved
// into the output register, which happens as soon as that register is empty or
// being read.
// If the receiver stalls, the result stays in the output register and the next
// result waits inside the block; no input item is taken until that one moves on.
// Reset (rst_n low, synchronous) empties every slot and clears the valid count and
// the run tally; slot values are not cleared, an empty slot is never matched.
module sparse_slot_table #(
  parameter int DEPTH       = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  sst_in_if.sink    in_if,
  sst_out_if.source out_if
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sst_pkg::state_t state_r, state_nxt;

  logic [sst_pkg::FUNC_W-1:0] func_r;
  logic [sst_pkg::IDX_W-1:0]  idx_r;
  logic [VALUE_WIDTH-1:0]     val_r;
  logic                       last_r;

  logic [CW-1:0] occ_r, occ_nxt;
  logic [CW-1:0] run_r, run_nxt;

  sst_pkg::res_t res_r, res_nxt;
  sst_pkg::res_t out_res_r;
  logic          out_valid_r, out_valid_nxt;

  logic          accept, out_free, in_rdy, in_range, sel_valid;
  logic          cell_wr, cell_clr, inject;
  logic [CW-1:0] run_inc;

  logic [DEPTH-1:0]   cell_valid;
  sst_pkg::tok_t      tok [DEPTH];
  sst_pkg::tok_t      tok_head;

  assign out_free = !out_valid_r || out_if.ready;
  assign in_rdy   = rst_n &&
                    ((state_r == sst_pkg::ST_IDLE) ||
                     ((state_r == sst_pkg::ST_HOLD) && out_free));
  assign accept   = in_if.valid && in_rdy;
  assign in_if.ready = in_rdy;

  assign in_range  = ({1'b0, idx_r} < sst_pkg::CNT_W'(DEPTH));
  assign sel_valid = in_range ? cell_valid[idx_r[IW-1:0]] : 1'b0;
  assign run_inc   = (run_r < CW'(DEPTH)) ? run_r + CW'(1) : run_r;
  assign tok_head  = '{active: inject, found: 1'b0, idx: '0};

  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    run_nxt       = run_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    cell_wr       = 1'b0;
    cell_clr      = 1'b0;
    inject        = 1'b0;
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      sst_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = sst_pkg::ST_EXEC;
        end
      end
      sst_pkg::ST_EXEC: begin
        res_nxt.placed      = 1'b0;
        res_nxt.found       = 1'b0;
        res_nxt.match_index = '0;
        res_nxt.status      = 1'b0;
        res_nxt.run_placed  = sst_pkg::CNT_W'(run_r);
        res_nxt.valid_count = sst_pkg::CNT_W'(occ_r);
        state_nxt           = sst_pkg::ST_HOLD;
        case (func_r)
          sst_pkg::FUNC_PUT: begin
            if (!in_range) begin
              res_nxt.status = 1'b1;
            end else if (!sel_valid) begin
              cell_wr             = 1'b1;
              occ_nxt             = occ_r + CW'(1);
              run_nxt             = run_inc;
              res_nxt.placed      = 1'b1;
              res_nxt.run_placed  = sst_pkg::CNT_W'(run_inc);
              res_nxt.valid_count = sst_pkg::CNT_W'(occ_r + CW'(1));
            end
            if (last_r) begin
              run_nxt = '0;
            end
          end
          sst_pkg::FUNC_FIND: begin
            inject    = 1'b1;
            state_nxt = sst_pkg::ST_WAIT;
          end
          sst_pkg::FUNC_DEL: begin
            if (!in_range) begin
              res_nxt.status = 1'b1;
            end else if (sel_valid) begin
              cell_clr            = 1'b1;
              occ_nxt             = occ_r - CW'(1);
              res_nxt.valid_count = sst_pkg::CNT_W'(occ_r - CW'(1));
            end
          end
          default: begin
          end
        endcase
      end
      sst_pkg::ST_WAIT: begin
        if (tok[DEPTH-1].active) begin
          res_nxt.found       = tok[DEPTH-1].found;
          res_nxt.match_index = tok[DEPTH-1].found ? tok[DEPTH-1].idx : '0;
          state_nxt           = sst_pkg::ST_HOLD;
        end
      end
      sst_pkg::ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = accept ? sst_pkg::ST_EXEC : sst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sst_pkg::ST_IDLE;
      occ_r       <= '0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (accept) begin
      func_r <= in_if.func;
      idx_r  <= in_if.slot_index;
      val_r  <= VALUE_WIDTH'(in_if.data_value);
      last_r <= in_if.run_last;
    end
    if ((state_r == sst_pkg::ST_HOLD) && out_free) begin
      out_res_r <= res_r;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    sst_pkg::cell_ctl_t ctl;
    logic               sel;

    assign sel     = (idx_r[IW-1:0] == IW'(g));
    assign ctl.wr  = cell_wr && sel;
    assign ctl.clr = cell_clr && sel;

    sst_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .CELL_INDEX  (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .wr_value (val_r),
      .key      (val_r),
      .tok_i    ((g == 0) ? tok_head : tok[(g == 0) ? 0 : g - 1]),
      .tok_o    (tok[g]),
      .valid_o  (cell_valid[g])
    );
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.placed      = out_res_r.placed;
  assign out_if.run_placed  = out_res_r.run_placed;
  assign out_if.found       = out_res_r.found;
  assign out_if.match_index = out_res_r.match_index;
  assign out_if.valid_count = out_res_r.valid_count;
  assign out_if.status      = out_res_r.status;

endmodule

@@ hdl/sst_checker.sv @@
// Port-level checker of the sparse slot table, bound to the top level.
`include "assert_macros.svh"

module sst_checker #(
  parameter int DEPTH = 256
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_placed,
  input logic                      out_found,
  input logic [sst_pkg::IDX_W-1:0] out_match_index,
  input logic [sst_pkg::CNT_W-1:0] out_valid_count,
  input logic                      out_status
);

  `SST_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_valid_count) && $stable(out_match_index))

  `SST_ASSERT_NOW(a_find_clean, clk, rst_n, out_valid && out_found,
    !out_placed && !out_status)

  `SST_ASSERT_NOW(a_nomatch_zero, clk, rst_n, out_valid && !out_found,
    out_match_index == '0)

  `SST_ASSERT_NOW(a_count_range, clk, rst_n, out_valid,
    out_valid_count <= sst_pkg::CNT_W'(DEPTH))

endmodule

bind sparse_slot_table sst_checker #(
  .DEPTH (DEPTH)
) u_sst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_placed      (out_if.placed),
  .out_found       (out_if.found),
  .out_match_index (out_if.match_index),
  .out_valid_count (out_if.valid_count),
  .out_status      (out_if.status)
);
